// ===== hdl/damped_force_step_with_speed_clamp_top_macros.svh =====
// ----------------------------------------------------------------------------
// Damped force step assertion macros
// Shorthand for clocked assertions on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DAMPED_FORCE_STEP_WITH_SPEED_CLAMP_TOP_MACROS_SVH
`define DAMPED_FORCE_STEP_WITH_SPEED_CLAMP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Damped force step package
// Payload types, register indexes, constants and fixed-point helpers shared
// by the damped force step modules.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int COMPONENTS = 64;
    localparam int VEL_AW     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

    // Damping 0.6 in Q16.16.
    localparam logic signed [32:0] DAMP_Q16 = 33'sd39322;

    localparam int ITER_STEPS = 32;
    localparam int ITER_CW    = $clog2(ITER_STEPS);

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAX_MOVE  = 2'd1;
    localparam logic [1:0] CFG_SETTLE    = 2'd2;

    // Modes of the shared iterative unit.
    localparam logic ITER_SQRT = 1'b0;
    localparam logic ITER_DIV  = 1'b1;

    typedef struct packed {
        logic [5:0]         component_index;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               pass_end;
    } dfs_in_t;

    typedef struct packed {
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic [30:0]        move_length;
        logic               last_of_pass;
        logic               settled;
    } dfs_out_t;

    typedef struct packed {
        logic start;
        logic mode;
    } dfs_iter_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dfs_iter_stat_t;

    // Shift a Q32.32 product down to Q16.16, rounding half up, then saturate.
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd32768) >>> 16;
        if (t > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (t < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [32:0] abs33(input logic signed [31:0] d);
        logic signed [32:0] e;
        e = {d[31], d};
        return d[31] ? -e : e;
    endfunction

endpackage

// ===== hdl/dfs_vel_ram.sv =====
// ----------------------------------------------------------------------------
// Velocity store
// One entry per component holding both velocity axes, with a valid bit per
// entry so that an entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module dfs_vel_ram (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [dfs_pkg::VEL_AW-1:0] rd_addr,
    output logic [63:0]               rd_data,
    input  logic                      wr_en,
    input  logic [dfs_pkg::VEL_AW-1:0] wr_addr,
    input  logic [63:0]               wr_data
);
    import dfs_pkg::*;

    logic [63:0]           mem [COMPONENTS];
    logic [COMPONENTS-1:0] vld_reg;
    logic [63:0]           rd_data_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : 64'd0;

endmodule

// ===== hdl/dfs_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 by 33 bit multiplier with a registered product that holds until
// the next enabled operation.
// ----------------------------------------------------------------------------
module dfs_mul (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [63:0] p
);
    import dfs_pkg::*;

    logic signed [65:0] prod;
    logic signed [63:0] p_reg;

    // Every operand pair used here has a product of at most 2^62 in magnitude.
    assign prod = a * b;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= prod[63:0];
        end
    end

    assign p = p_reg;

endmodule

// ===== hdl/dfs_iter.sv =====
// ----------------------------------------------------------------------------
// Shared iterative root and divide unit
// One subtract-and-compare per cycle: a square root of a 64-bit value or the
// quotient of a 64-bit numerator by a 32-bit divisor, 32 steps either way.
// ----------------------------------------------------------------------------
`include "damped_force_step_with_speed_clamp_top_macros.svh"

module dfs_iter (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dfs_pkg::dfs_iter_cmd_t  cmd,
    input  logic [63:0]             operand,
    input  logic [31:0]             divisor,
    output dfs_pkg::dfs_iter_stat_t stat,
    output logic [31:0]             result
);
    import dfs_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic              mode_reg;
    logic [ITER_CW-1:0] cnt_reg;
    logic [33:0]       rem_reg;
    logic [31:0]       root_reg;
    logic [63:0]       src_reg;
    logic [31:0]       dvs_reg;

    logic [35:0] t;
    logic [35:0] trial;
    logic [36:0] diff;
    logic        ge;
    logic [33:0] rem_next;
    logic [63:0] src_next;

    // For the root, two bits of the radicand come down per step; for the
    // quotient, one bit of the numerator.
    always_comb begin
        if (mode_reg == ITER_SQRT) begin
            t        = {rem_reg, src_reg[63:62]};
            trial    = {2'b00, root_reg, 2'b01};
            src_next = {src_reg[61:0], 2'b00};
        end else begin
            t        = {3'b000, rem_reg[31:0], src_reg[63]};
            trial    = {4'b0000, dvs_reg};
            src_next = {src_reg[62:0], 1'b0};
        end
        diff     = {1'b0, t} - {1'b0, trial};
        ge       = ~diff[36];
        rem_next = ge ? diff[33:0] : t[33:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg <= cmd.mode;
            root_reg <= '0;
            dvs_reg  <= divisor;
            if (cmd.mode == ITER_SQRT) begin
                rem_reg <= '0;
                src_reg <= operand;
            end else begin
                rem_reg <= {2'b00, operand[63:32]};
                src_reg <= {operand[31:0], 32'd0};
            end
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            root_reg <= {root_reg[30:0], ge};
            src_reg  <= src_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ITER_CW'(ITER_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = root_reg;

    `DFS_ASSERT_NEXT(a_start_busy, cmd.start, busy_reg, "iterative unit did not start")
    `DFS_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "iterative unit done while busy")
    `DFS_ASSERT_NOW(a_start_free, cmd.start, !busy_reg, "iterative unit restarted while busy")

endmodule

// ===== hdl/damped_force_step_with_speed_clamp_top.sv =====
// Damped force step with speed clamp. Each accepted beat carries one
// component's summed force; the block reads that component's stored
// velocity, forms 0.6 * velocity + step_size * force per axis with one shared
// multiplier, and takes the length with an iterative root unit that retires
// one result bit per cycle. An item whose move stays within max_movement
// offers its result beat after a single root; a clamped item runs two
// 32-step divisions and a second root through the same unit. The next beat
// can be taken in the same cycle as the result is offered. The block takes
// one item at a time and accepts the next one while a finished result still
// waits in the output register; a result only stalls the sequencer when the
// previous one has not yet been taken. Configuration registers: index 0
// step_size, 1 max_movement, 2 settle_threshold; other indexes are ignored.
// ----------------------------------------------------------------------------
// Damped force step with speed clamp, top level
// Sequencer around the velocity store, the shared multiplier and the shared
// iterative root and divide unit.
// ----------------------------------------------------------------------------
`include "damped_force_step_with_speed_clamp_top_macros.svh"

module damped_force_step_with_speed_clamp_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dfs_pkg::dfs_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output dfs_pkg::dfs_out_t m_payload,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [30:0]       cfg_wdata
);
    import dfs_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_VX     = 5'd1;
    localparam logic [4:0] S_VY     = 5'd2;
    localparam logic [4:0] S_FX     = 5'd3;
    localparam logic [4:0] S_FY     = 5'd4;
    localparam logic [4:0] S_PY     = 5'd5;
    localparam logic [4:0] S_SQX    = 5'd6;
    localparam logic [4:0] S_SQY    = 5'd7;
    localparam logic [4:0] S_ROOT   = 5'd8;
    localparam logic [4:0] S_ROOT_W = 5'd9;
    localparam logic [4:0] S_CX     = 5'd10;
    localparam logic [4:0] S_DIVX   = 5'd11;
    localparam logic [4:0] S_DIVX_W = 5'd12;
    localparam logic [4:0] S_CY     = 5'd13;
    localparam logic [4:0] S_DIVY   = 5'd14;
    localparam logic [4:0] S_DIVY_W = 5'd15;
    localparam logic [4:0] S_FIN    = 5'd16;

    logic [4:0]  state_reg, state_next;
    logic [30:0] step_size_reg;
    logic [30:0] max_move_reg;
    logic [30:0] settle_reg;
    logic [30:0] largest_reg;

    dfs_in_t            item_reg;
    logic               in_range_reg;
    logic               clamped_reg;
    logic signed [31:0] damp_x_reg, damp_y_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        len_reg;
    dfs_out_t           out_reg;
    logic               m_valid_reg;

    logic               accept;
    logic               out_go;
    logic [63:0]        ram_rd_data;
    logic               ram_wr_en;
    logic [63:0]        ram_wr_data;
    logic signed [31:0] vel_x, vel_y;

    logic               mul_en;
    logic signed [32:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    dfs_iter_cmd_t      iter_cmd;
    dfs_iter_stat_t     iter_stat;
    logic [63:0]        iter_operand;
    logic [31:0]        iter_result;
    logic signed [31:0] q_signed;

    logic [30:0]        len31;
    logic [30:0]        largest_cand;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign out_go  = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= 31'd65536;
            max_move_reg  <= 31'd655360;
            settle_reg    <= 31'd66;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_SIZE: step_size_reg <= cfg_wdata;
                CFG_MAX_MOVE:  max_move_reg  <= cfg_wdata;
                CFG_SETTLE:    settle_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Velocity store
    // ------------------------------------------------------------------
    assign ram_wr_en   = (state_reg == S_FIN) && out_go && in_range_reg;
    assign ram_wr_data = (len_reg == 32'd0) ? 64'd0 : {dx_reg, dy_reg};

    dfs_vel_ram u_vel_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (VEL_AW'(s_payload.component_index)),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (VEL_AW'(item_reg.component_index)),
        .wr_data (ram_wr_data)
    );

    assign vel_x = in_range_reg ? ram_rd_data[63:32] : 32'sd0;
    assign vel_y = in_range_reg ? ram_rd_data[31:0]  : 32'sd0;

    // ------------------------------------------------------------------
    // Shared multiplier operand selection
    // ------------------------------------------------------------------
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_VX: begin
                mul_a = {vel_x[31], vel_x};
                mul_b = DAMP_Q16;
            end
            S_VY: begin
                mul_a = {vel_y[31], vel_y};
                mul_b = DAMP_Q16;
            end
            S_FX: begin
                mul_a = {2'b00, step_size_reg};
                mul_b = {item_reg.force_x[31], item_reg.force_x};
            end
            S_FY: begin
                mul_a = {2'b00, step_size_reg};
                mul_b = {item_reg.force_y[31], item_reg.force_y};
            end
            S_SQX: begin
                mul_a = {dx_reg[31], dx_reg};
                mul_b = {dx_reg[31], dx_reg};
            end
            S_SQY: begin
                mul_a = {dy_reg[31], dy_reg};
                mul_b = {dy_reg[31], dy_reg};
            end
            S_CX: begin
                mul_a = abs33(dx_reg);
                mul_b = {2'b00, max_move_reg};
            end
            S_CY: begin
                mul_a = abs33(dy_reg);
                mul_b = {2'b00, max_move_reg};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    dfs_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // ------------------------------------------------------------------
    // Shared root and divide unit
    // ------------------------------------------------------------------
    always_comb begin
        iter_cmd.start = (state_reg == S_ROOT) || (state_reg == S_DIVX) ||
                         (state_reg == S_DIVY);
        iter_cmd.mode  = (state_reg == S_ROOT) ? ITER_SQRT : ITER_DIV;
        // In the root state the product register holds dy squared.
        iter_operand   = (state_reg == S_ROOT) ? (sum_reg + 64'(mul_p)) : 64'(mul_p);
    end

    dfs_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (iter_cmd),
        .operand (iter_operand),
        .divisor (len_reg),
        .stat    (iter_stat),
        .result  (iter_result)
    );

    // The scaled magnitude never exceeds max_movement, so bit 31 is clear.
    assign q_signed = {1'b0, iter_result[30:0]};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_VX;
            S_VX:     state_next = S_VY;
            S_VY:     state_next = S_FX;
            S_FX:     state_next = S_FY;
            S_FY:     state_next = S_PY;
            S_PY:     state_next = S_SQX;
            S_SQX:    state_next = S_SQY;
            S_SQY:    state_next = S_ROOT;
            S_ROOT:   state_next = S_ROOT_W;
            S_ROOT_W: begin
                if (iter_stat.done) begin
                    if (!clamped_reg && (iter_result > {1'b0, max_move_reg})) begin
                        state_next = S_CX;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_CX:     state_next = S_DIVX;
            S_DIVX:   state_next = S_DIVX_W;
            S_DIVX_W: if (iter_stat.done) state_next = S_CY;
            S_CY:     state_next = S_DIVY;
            S_DIVY:   state_next = S_DIVY_W;
            S_DIVY_W: if (iter_stat.done) state_next = S_SQX;
            S_FIN:    if (out_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    item_reg     <= s_payload;
                    in_range_reg <= (32'(s_payload.component_index) < 32'(COMPONENTS));
                    clamped_reg  <= 1'b0;
                end
            end
            S_VY:  damp_x_reg <= round_sat(mul_p);
            S_FX:  damp_y_reg <= round_sat(mul_p);
            S_FY:  dx_reg     <= add_sat(damp_x_reg, round_sat(mul_p));
            S_PY:  dy_reg     <= add_sat(damp_y_reg, round_sat(mul_p));
            S_SQY: sum_reg    <= 64'(mul_p);
            S_ROOT_W: begin
                if (iter_stat.done) begin
                    len_reg <= iter_result;
                end
            end
            S_DIVX_W: begin
                if (iter_stat.done) begin
                    dx_reg <= dx_reg[31] ? -q_signed : q_signed;
                end
            end
            S_DIVY_W: begin
                if (iter_stat.done) begin
                    dy_reg      <= dy_reg[31] ? -q_signed : q_signed;
                    clamped_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Pass tracking and result register
    // ------------------------------------------------------------------
    assign len31        = len_reg[30:0];
    assign largest_cand = (len31 > largest_reg) ? len31 : largest_reg;

    always_ff @(posedge aclk) begin
        if ((state_reg == S_FIN) && out_go) begin
            out_reg.move_x       <= dx_reg;
            out_reg.move_y       <= dy_reg;
            out_reg.move_length  <= len31;
            out_reg.last_of_pass <= item_reg.pass_end;
            out_reg.settled      <= item_reg.pass_end && (largest_cand < settle_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            largest_reg <= '0;
        end else begin
            if ((state_reg == S_FIN) && out_go) begin
                m_valid_reg <= 1'b1;
                largest_reg <= item_reg.pass_end ? 31'd0 : largest_cand;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    `DFS_ASSERT_NEXT(a_one_item, accept, !s_ready, "a second beat was taken while busy")
    `DFS_ASSERT_NOW(a_settled_last, m_valid && m_payload.settled, m_payload.last_of_pass, "settled flag outside a pass end")
    `DFS_ASSERT_NOW(a_idle_unit_free, state_reg == S_IDLE, !iter_stat.busy, "root unit busy while idle")

endmodule
